[design/itf_pkg.sv]
// ----------------------------------------------------------------------------
// itf_pkg
// Shared types, constants and helpers for the integer-to-text field formatter.
// ----------------------------------------------------------------------------
package itf_pkg;

  localparam int MAG_W         = 64;
  localparam int NDIG          = 22;               // octal needs 22 digits for 64 bits
  localparam int ND_W          = $clog2(NDIG + 1);
  localparam int OCT_BITS      = NDIG * 3;
  localparam int HEX_BITS      = NDIG * 4;
  localparam int CNT_W         = 8;                // holds any field length, signed
  localparam int MAX_FIELD_DEF = 40;
  localparam int MAX_OUT       = 42;
  localparam int FW_W          = 6;

  // flag_bits positions
  localparam int FB_LEFT  = 0;
  localparam int FB_ZERO  = 1;
  localparam int FB_PLUS  = 2;
  localparam int FB_SPACE = 3;
  localparam int FB_ALT   = 4;

  // radix_select codes; the unused code acts as hexadecimal
  localparam logic [1:0] RADIX_OCT = 2'd0;
  localparam logic [1:0] RADIX_DEC = 2'd1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_A_UP  = 8'h41;

  typedef struct packed {
    logic             neg;
    logic [1:0]       radix;
    logic             upper;
    logic             sgn;
    logic [4:0]       flags;
    logic [FW_W-1:0]  width;
    logic             has_prec;
    logic [FW_W-1:0]  prec;
    logic             nonzero;
  } itf_fmt_t;

  typedef struct packed {
    logic            done;
    logic [ND_W-1:0] count;
    logic [3:0]      digit;
  } itf_dig_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_A_UP : CH_A_LO;
    if (d < 4'd10) return CH_ZERO + {4'b0, d};
    else           return base + {4'b0, d} - 8'd10;
  endfunction

endpackage

[design/integer_to_text_field.sv]
// Flow: after the input transfer the converter builds the digit row (decimal by a
// bit-serial pass over all 64 magnitude bits) and strips up to 21 leading zero
// digits from the 22-digit row; the sequencer then works out the layout and emits.
// Throughput: one item at a time; the input stays held until the item's last
// character is loaded into the output register, and output stalls hold it longer.
// Reset: synchronous; clears the control state and drops any item in flight.
// ----------------------------------------------------------------------------
// integer_to_text_field
// Formats one integer as a printf-style text field, one character per output
// transfer, with tlast on the final character.
// ----------------------------------------------------------------------------
module integer_to_text_field #(
  parameter int MAX_FIELD = itf_pkg::MAX_FIELD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [63:0] magnitude, [64] is_negative, [66:65] radix_select, [67] upper_case,
  // [68] signed_conversion, [73:69] flag_bits, [79:74] field_width,
  // [80] has_precision, [86:81] precision, [87] unused
  input  logic [87:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_char
  output logic        m_tlast    // last_char
);
  import itf_pkg::*;

  localparam logic [FW_W-1:0] FIELD_CAP = FW_W'(MAX_FIELD);

  logic               accept;
  logic               seq_idle;
  logic               pop;
  itf_fmt_t           fmt;
  itf_dig_t           dig;

  logic [MAG_W-1:0]   in_mag;
  logic [FW_W-1:0]    in_width, in_prec;
  logic               in_has_prec;

  assign in_mag      = s_tdata[63:0];
  assign in_width    = s_tdata[79:74];
  assign in_has_prec = s_tdata[80];
  assign in_prec     = s_tdata[86:81];

  assign s_tready = seq_idle;
  assign accept   = s_tvalid && s_tready;

  // hold the item's format settings for the whole field
  always_ff @(posedge clk) begin
    if (accept) begin
      fmt.neg      <= s_tdata[64];
      fmt.radix    <= s_tdata[66:65];
      fmt.upper    <= s_tdata[67];
      fmt.sgn      <= s_tdata[68];
      fmt.flags    <= s_tdata[73:69];
      fmt.width    <= (in_width > FIELD_CAP) ? FIELD_CAP : in_width;
      fmt.has_prec <= in_has_prec;
      fmt.prec     <= (in_prec > FIELD_CAP) ? FIELD_CAP : in_prec;
      fmt.nonzero  <= (in_mag != '0);
    end
  end

  itf_digit_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .magnitude (in_mag),
    .radix     (s_tdata[66:65]),
    .no_digits ((in_mag == '0) && in_has_prec && (in_prec == '0)),
    .pop       (pop),
    .dig       (dig)
  );

  itf_field_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .fmt      (fmt),
    .dig      (dig),
    .pop      (pop),
    .idle     (seq_idle),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

[design/itf_digit_conv.sv]
// ----------------------------------------------------------------------------
// itf_digit_conv
// Turns the magnitude into a row of digits, most significant first. Decimal
// uses a bit-serial shift-and-add-3 pass; octal and hex load by regrouping.
// Leading zero digits are then shifted out one per cycle.
// ----------------------------------------------------------------------------
module itf_digit_conv (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [itf_pkg::MAG_W-1:0] magnitude,
  input  logic [1:0]              radix,
  input  logic                    no_digits,
  input  logic                    pop,
  output itf_pkg::itf_dig_t       dig
);
  import itf_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DABBLE, S_NORM} state_t;

  state_t                   state;
  logic [NDIG-1:0][3:0]     digs;
  logic [MAG_W-1:0]         shreg;
  logic [$clog2(MAG_W+1)-1:0] bit_cnt;
  logic [ND_W-1:0]          nd;
  logic                     drop;
  logic                     done;

  logic [NDIG-1:0][3:0]     load_digs;
  logic [NDIG-1:0][3:0]     adj_digs;
  logic [OCT_BITS-1:0]      oct_ext;
  logic [HEX_BITS-1:0]      hex_ext;
  logic                     strip;

  always_comb begin
    oct_ext = {{(OCT_BITS-MAG_W){1'b0}}, magnitude};
    hex_ext = {{(HEX_BITS-MAG_W){1'b0}}, magnitude};
    for (int i = 0; i < NDIG; i++) begin
      if (radix == RADIX_OCT)      load_digs[i] = {1'b0, oct_ext[3*i +: 3]};
      else if (radix == RADIX_DEC) load_digs[i] = 4'd0;
      else                         load_digs[i] = hex_ext[4*i +: 4];
      adj_digs[i] = (digs[i] >= 4'd5) ? digs[i] + 4'd3 : digs[i];
    end
    strip = (digs[NDIG-1] == 4'd0) && (nd > ND_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      nd    <= '0;
    end else begin
      done <= (state == S_NORM) && !strip;
      case (state)
        S_IDLE: begin
          if (start) begin
            digs    <= load_digs;
            shreg   <= magnitude;
            bit_cnt <= ($clog2(MAG_W+1))'(MAG_W);
            nd      <= ND_W'(NDIG);
            drop    <= no_digits;
            state   <= (radix == RADIX_DEC) ? S_DABBLE : S_NORM;
          end else if (pop) begin
            digs <= {digs[NDIG-2:0], 4'd0};
          end
        end
        S_DABBLE: begin
          // add 3 to every digit of 5 or more, then shift in the next bit
          digs    <= {adj_digs[NDIG-1][2:0], adj_digs[NDIG-2:0], shreg[MAG_W-1]};
          shreg   <= {shreg[MAG_W-2:0], 1'b0};
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == 1) state <= S_NORM;
        end
        S_NORM: begin
          if (strip) begin
            digs <= {digs[NDIG-2:0], 4'd0};
            nd   <= nd - 1'b1;
          end else begin
            if (drop) nd <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign dig.done  = done;
  assign dig.count = nd;
  assign dig.digit = digs[NDIG-1];

endmodule

[design/itf_field_seq.sv]
// ----------------------------------------------------------------------------
// itf_field_seq
// Works out the field layout (pad, prefix, leading zeros, digits, trailing
// pad) and emits one character per transfer through an output register.
// ----------------------------------------------------------------------------
module itf_field_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  itf_pkg::itf_fmt_t fmt,
  input  itf_pkg::itf_dig_t dig,
  output logic              pop,
  output logic              idle,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,    // [7:0] out_char
  output logic              m_tlast     // last_char
);
  import itf_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CONV, S_SETUP, S_BOUNDS, S_EMIT} state_t;

  state_t                   state;
  logic [2:0][7:0]          pre;
  logic [1:0]               np;
  logic [CNT_W-1:0]         zeros;
  logic [CNT_W-1:0]         b1, b2, b3, b4, total, k;

  // layout terms
  logic                     left, is_hex, sign_on, hex_pre;
  logic [7:0]               sign_ch, x_ch;
  logic signed [CNT_W-1:0]  nd_s, np_s, w_s, p_s, z_raw, z_fix, pad_raw, pad;
  logic [CNT_W-1:0]         padl, n_all;

  // emit terms
  logic                     emit;
  logic                     in_pre, in_dig;
  logic [7:0]               ch;

  always_comb begin
    left    = fmt.flags[FB_LEFT];
    is_hex  = (fmt.radix != RADIX_OCT) && (fmt.radix != RADIX_DEC);
    sign_on = fmt.neg || (fmt.sgn && (fmt.flags[FB_PLUS] || fmt.flags[FB_SPACE]));
    sign_ch = fmt.neg ? CH_MINUS : (fmt.flags[FB_PLUS] ? CH_PLUS : CH_SPACE);
    x_ch    = fmt.upper ? CH_X_UP : CH_X_LO;
    hex_pre = fmt.flags[FB_ALT] && is_hex && fmt.nonzero;
    nd_s    = CNT_W'(dig.count);
    np_s    = CNT_W'({1'b0, hex_pre, 1'b0}) + CNT_W'(sign_on);
    w_s     = CNT_W'(fmt.width);
    p_s     = CNT_W'(fmt.prec);

    if (fmt.has_prec && p_s > nd_s)
      z_raw = p_s - nd_s;
    else if (fmt.flags[FB_ZERO] && !fmt.has_prec && !left)
      z_raw = w_s - np_s - nd_s;
    else
      z_raw = '0;
    if (z_raw < 0) z_raw = '0;
    z_fix = z_raw;
    // octal alternate form: force one leading zero unless a zero leads already
    if (fmt.flags[FB_ALT] && fmt.radix == RADIX_OCT && z_raw == 0 &&
        (dig.count == 0 || fmt.nonzero))
      z_fix = CNT_W'(1);

    pad_raw = w_s - CNT_W'(np) - $signed(zeros) - nd_s;
    pad     = (pad_raw < 0) ? '0 : pad_raw;
    padl    = left ? '0 : pad;
    n_all   = CNT_W'(padl + CNT_W'(np) + zeros + CNT_W'(dig.count)) + (left ? pad : '0);

    emit   = (state == S_EMIT) && (!m_tvalid || m_tready);
    in_pre = (k >= b1) && (k < b2);
    in_dig = (k >= b3) && (k < b4);
    if (k < b1)       ch = CH_SPACE;
    else if (in_pre)  ch = pre[0];
    else if (k < b3)  ch = CH_ZERO;
    else if (in_dig)  ch = digit_char(dig.digit, fmt.upper);
    else              ch = CH_SPACE;
  end

  assign pop  = emit && in_dig;
  assign idle = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (emit)          m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) state <= S_CONV;
        end
        S_CONV: begin
          if (dig.done) state <= S_SETUP;
        end
        S_SETUP: begin
          np    <= np_s[1:0];
          zeros <= z_fix;
          if (sign_on) pre <= {x_ch, CH_ZERO, sign_ch};
          else         pre <= {8'h00, x_ch, CH_ZERO};
          state <= S_BOUNDS;
        end
        S_BOUNDS: begin
          b1    <= padl;
          b2    <= padl + CNT_W'(np);
          b3    <= padl + CNT_W'(np) + zeros;
          b4    <= padl + CNT_W'(np) + zeros + CNT_W'(dig.count);
          total <= (n_all > CNT_W'(MAX_OUT)) ? CNT_W'(MAX_OUT) : n_all;
          k     <= '0;
          state <= (n_all == 0) ? S_IDLE : S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            m_tdata  <= ch;
            m_tlast  <= (k == total - 1'b1);
            if (in_pre) pre <= {8'h00, pre[2], pre[1]};
            k <= k + 1'b1;
            if (k == total - 1'b1) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[verif/tb_integer_to_text_field.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_to_text_field
// Self-checking bench for the printf-style integer formatter. Numbers go in
// as packed stream transfers in bursts with random gaps. A scoreboard works
// out the text field of every accepted number and checks each output
// character and its tlast against the oldest expected one. The receiver
// stalls on its own pattern, including one long hold-off that backs up the
// input side.
// ----------------------------------------------------------------------------
module tb_integer_to_text_field;
  import itf_pkg::*;

  localparam int MAX_FIELD  = itf_pkg::MAX_FIELD_DEF;
  localparam int N_RANDOM   = 108;
  localparam int LONG_HOLD  = 400;
  localparam int TAIL_WAIT  = 200;

  localparam logic [1:0] RADIX_HEX     = 2'd2;
  localparam logic [1:0] RADIX_SPARE   = 2'd3;

  localparam logic [4:0] F_NONE  = 5'd0;
  localparam logic [4:0] F_LEFT  = 5'd1 << FB_LEFT;
  localparam logic [4:0] F_ZERO  = 5'd1 << FB_ZERO;
  localparam logic [4:0] F_PLUS  = 5'd1 << FB_PLUS;
  localparam logic [4:0] F_SPACE = 5'd1 << FB_SPACE;
  localparam logic [4:0] F_ALT   = 5'd1 << FB_ALT;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [87:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  int err_count = 0;
  int burst_left = 0;
  bit hold_off_req = 0;

  integer_to_text_field DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  class text_field_board;
    logic [8:0] expected_chars[$];  // {last, char}
    string lo_set = "0123456789abcdef";
    string up_set = "0123456789ABCDEF";

    function int clamp_field(logic [5:0] v);
      return (v > MAX_FIELD) ? MAX_FIELD : int'(v);
    endfunction

    // Build the whole field for one accepted number and queue its characters.
    function void note_number(logic [87:0] d);
      logic [63:0] mag;
      logic [63:0] m;
      logic [63:0] radix;
      logic [1:0]  rsel;
      logic [4:0]  flags;
      logic        neg, upper, sgn, has_prec, nonzero;
      int          width, prec, nd, np, zeros, pad, cnt, i;
      byte unsigned digs[$];
      byte unsigned pre[$];
      byte unsigned field[$];
      mag      = d[63:0];
      neg      = d[64];
      rsel     = d[66:65];
      upper    = d[67];
      sgn      = d[68];
      flags    = d[73:69];
      width    = clamp_field(d[79:74]);
      has_prec = d[80];
      prec     = clamp_field(d[86:81]);
      nonzero  = (mag != 64'd0);
      radix    = (rsel == RADIX_OCT) ? 64'd8 : (rsel == RADIX_DEC) ? 64'd10 : 64'd16;

      // digits, least significant first; none for zero at precision zero
      if (nonzero || !has_prec || prec != 0) begin
        m = mag;
        do begin
          digs.push_back(upper ? up_set[int'(m % radix)] : lo_set[int'(m % radix)]);
          m = m / radix;
        end while (m != 64'd0);
      end
      nd = digs.size();

      if (neg) pre.push_back(CH_MINUS);
      else if (sgn && flags[FB_PLUS]) pre.push_back(CH_PLUS);
      else if (sgn && flags[FB_SPACE]) pre.push_back(CH_SPACE);
      if (flags[FB_ALT] && radix == 64'd16 && nonzero) begin
        pre.push_back(CH_ZERO);
        pre.push_back(upper ? CH_X_UP : CH_X_LO);
      end
      np = pre.size();

      zeros = 0;
      if (has_prec && prec > nd) zeros = prec - nd;
      else if (flags[FB_ZERO] && !has_prec && !flags[FB_LEFT]) zeros = width - np - nd;
      if (zeros < 0) zeros = 0;
      if (flags[FB_ALT] && radix == 64'd8 && zeros == 0 &&
          (nd == 0 || digs[nd-1] != CH_ZERO))
        zeros = 1;

      pad = width - np - zeros - nd;
      if (pad < 0) pad = 0;

      if (!flags[FB_LEFT]) for (i = 0; i < pad; i++) field.push_back(CH_SPACE);
      foreach (pre[k]) field.push_back(pre[k]);
      for (i = 0; i < zeros; i++) field.push_back(CH_ZERO);
      for (i = nd - 1; i >= 0; i--) field.push_back(digs[i]);
      if (flags[FB_LEFT]) for (i = 0; i < pad; i++) field.push_back(CH_SPACE);

      // an overlong field is cut, the last kept character carries tlast
      cnt = (field.size() > MAX_OUT) ? MAX_OUT : field.size();
      for (i = 0; i < cnt; i++)
        expected_chars.push_back({(i == cnt - 1), field[i]});
    endfunction

    // Empty string when the character matches the oldest expectation.
    function string check_char(logic [7:0] ch, logic last);
      logic [8:0] e;
      string msg;
      if (expected_chars.size() == 0)
        return $sformatf("unexpected char 0x%02h tlast %0b", ch, last);
      e = expected_chars.pop_front();
      msg = "";
      if (ch !== e[7:0])
        msg = $sformatf("char got 0x%02h exp 0x%02h", ch, e[7:0]);
      if (last !== e[8])
        msg = {msg, $sformatf(" tlast got %0b exp %0b", last, e[8])};
      return msg;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  text_field_board board = new();

  task automatic report_mismatch(input string msg);
    if (err_count < 50)
      $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic logic [87:0] pack_number(
    input logic [63:0] mag, input logic neg, input logic [1:0] rsel,
    input logic upper, input logic sgn, input logic [4:0] flags,
    input logic [5:0] width, input logic has_prec, input logic [5:0] prec);
    return {1'b0, prec, has_prec, width, flags, sgn, upper, rsel, neg, mag};
  endfunction

  function automatic logic [87:0] random_number();
    logic [63:0] mag;
    logic [5:0]  width, prec;
    logic [1:0]  rsel;
    int          k;
    case ($urandom_range(0, 7))
      0: mag = 64'd0;
      1: mag = 64'($urandom_range(0, 20));
      2: mag = {32'd0, $urandom()};
      3, 4: mag = {$urandom(), $urandom()};
      5: mag = ~64'd0;
      6: begin
        k = $urandom_range(0, 63);
        mag = 64'd1 << k;
        if ($urandom_range(0, 1)) mag = mag - 64'd1;
      end
      default: mag = {$urandom(), $urandom()} >> $urandom_range(0, 63);
    endcase
    width = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 20));
    prec  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 12));
    rsel  = ($urandom_range(0, 9) == 0) ? RADIX_SPARE : 2'($urandom_range(0, 2));
    return pack_number(mag, ($urandom_range(0, 3) == 0), rsel, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)), width,
                       ($urandom_range(0, 9) < 4), prec);
  endfunction

  // Offer one number; open a new burst after a random gap when the last ran out.
  task automatic offer_number(input logic [87:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    board.note_number(d);
    burst_left--;
  endtask

  // Hold the input idle until every queued character has come out.
  task automatic wait_field_drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_integer_to_text_field failed");
    $finish;
  end

  // receiver: random segments of always-ready, coin-flip, mostly-ready and
  // mostly-stalled, plus one long hold-off on request
  initial begin
    int seg_left;
    int style;
    seg_left = 0;
    style = 0;
    m_tready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(1, 40);
          style = $urandom_range(0, 3);
        end
        seg_left--;
        case (style)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 7) != 0);
          default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    string msg;
    if (!rst && m_tvalid && m_tready) begin
      msg = board.check_char(m_tdata, m_tlast);
      if (msg != "") report_mismatch(msg);
    end
  end

  initial begin
    logic [87:0] directed[$];
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    directed.push_back(pack_number(64'd0, 1'b0, RADIX_DEC, 1'b0, 1'b1, F_NONE, 6'd0,
                                   1'b0, 6'd0));
    directed.push_back(pack_number(~64'd0, 1'b0, RADIX_DEC, 1'b0, 1'b0, F_NONE, 6'd0,
                                   1'b0, 6'd0));
    directed.push_back(pack_number(~64'd0, 1'b0, RADIX_OCT, 1'b0, 1'b0, F_ALT, 6'd0,
                                   1'b0, 6'd0));
    directed.push_back(pack_number(~64'd0, 1'b0, RADIX_HEX, 1'b1, 1'b0, F_ALT, 6'd20,
                                   1'b0, 6'd0));
    // zero at precision zero: empty field
    directed.push_back(pack_number(64'd0, 1'b0, RADIX_DEC, 1'b0, 1'b1, F_NONE, 6'd0,
                                   1'b1, 6'd0));
    directed.push_back(pack_number(64'd0, 1'b0, RADIX_OCT, 1'b0, 1'b0, F_ALT, 6'd0,
                                   1'b1, 6'd0));
    directed.push_back(pack_number(64'd0, 1'b0, RADIX_HEX, 1'b0, 1'b0, F_ALT, 6'd4,
                                   1'b0, 6'd0));
    directed.push_back(pack_number(64'd42, 1'b0, RADIX_DEC, 1'b0, 1'b1, F_PLUS, 6'd0,
                                   1'b0, 6'd0));
    directed.push_back(pack_number(64'd42, 1'b0, RADIX_DEC, 1'b0, 1'b1, F_SPACE, 6'd5,
                                   1'b0, 6'd0));
    directed.push_back(pack_number(64'd7, 1'b0, RADIX_DEC, 1'b0, 1'b1, F_PLUS | F_SPACE, 6'd0,
                                   1'b0, 6'd0));
    directed.push_back(pack_number(64'd7, 1'b0, RADIX_DEC, 1'b0, 1'b0, F_PLUS | F_SPACE, 6'd3,
                                   1'b0, 6'd0));
    directed.push_back(pack_number(64'd42, 1'b1, RADIX_DEC, 1'b0, 1'b1, F_ZERO, 6'd10,
                                   1'b0, 6'd0));
    directed.push_back(pack_number(64'd42, 1'b0, RADIX_DEC, 1'b0, 1'b1, F_ZERO, 6'd10,
                                   1'b1, 6'd4));
    directed.push_back(pack_number(64'd42, 1'b1, RADIX_DEC, 1'b0, 1'b1, F_ZERO | F_LEFT, 6'd10,
                                   1'b0, 6'd0));
    directed.push_back(pack_number(64'd99, 1'b0, RADIX_DEC, 1'b0, 1'b0, F_NONE, 6'd63,
                                   1'b0, 6'd0));
    directed.push_back(pack_number(64'd99, 1'b0, RADIX_DEC, 1'b0, 1'b0, F_LEFT, 6'd63,
                                   1'b1, 6'd63));
    // minus, 0x and full precision overflow the output and get cut
    directed.push_back(pack_number(64'hABC, 1'b1, RADIX_HEX, 1'b0, 1'b1, F_ALT, 6'd0,
                                   1'b1, 6'd63));
    directed.push_back(pack_number(64'hDEADBEEF, 1'b0, RADIX_SPARE, 1'b1, 1'b0, F_ALT, 6'd0,
                                   1'b0, 6'd0));
    directed.push_back(pack_number(64'd8, 1'b0, RADIX_OCT, 1'b0, 1'b0, F_ALT, 6'd0,
                                   1'b1, 6'd5));
    directed.push_back(pack_number(64'd8, 1'b0, RADIX_OCT, 1'b0, 1'b0, F_ALT, 6'd6,
                                   1'b0, 6'd0));
    directed.push_back(pack_number(64'd5, 1'b1, RADIX_DEC, 1'b0, 1'b0, F_NONE, 6'd0,
                                   1'b0, 6'd0));
    directed.push_back(pack_number(64'h1234, 1'b0, RADIX_HEX, 1'b0, 1'b0, F_ZERO | F_ALT, 6'd12,
                                   1'b0, 6'd0));
    directed.push_back(pack_number(64'h8000000000000000, 1'b1, RADIX_OCT, 1'b1, 1'b1, 5'h1F,
                                   6'd40, 1'b1, 6'd40));
    foreach (directed[i]) offer_number(directed[i]);
    wait_field_drain();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 40) begin
        // stall the output long enough that the input backs up
        wait_field_drain();
        hold_off_req = 1;
        burst_left = 8;
      end
      if (n == 90) wait_field_drain();
      offer_number(random_number());
    end

    wait_field_drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (err_count == 0 && board.pending() == 0)
      $display("tb_integer_to_text_field passed");
    else
      $display("tb_integer_to_text_field failed");
    $finish;
  end

endmodule

[sim.f]
design/itf_pkg.sv
design/itf_digit_conv.sv
design/itf_field_seq.sv
design/integer_to_text_field.sv
verif/tb_integer_to_text_field.sv
